// ----- rtl/vwib_pkg.sv -----
package vwib_pkg;

  localparam int unsigned IdxW    = 10;
  localparam int unsigned CountW  = 11;
  localparam int unsigned TolW    = 31;
  localparam int unsigned FieldW  = 32;
  localparam int unsigned NCorner = 3;

  // Squared distance: three squares of up to 33-bit differences.
  localparam int unsigned DistW = 68;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic start;
    logic valid;
    logic last;
  } lane_ctrl_t;

endpackage

// ----- rtl/vwib_lane.sv -----
// One search lane: squared distance of a stored vertex to one corner, with a
// running minimum that keeps the first entry on ties.
module vwib_lane #(
  parameter int unsigned CW = 32,
  parameter int unsigned AW = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  vwib_pkg::lane_ctrl_t     ctrl_i,
  input  logic signed [CW-1:0]     cx_i,
  input  logic signed [CW-1:0]     cy_i,
  input  logic signed [CW-1:0]     cz_i,
  input  logic signed [CW-1:0]     sx_i,
  input  logic signed [CW-1:0]     sy_i,
  input  logic signed [CW-1:0]     sz_i,
  input  logic [AW-1:0]            addr_i,
  input  logic [vwib_pkg::TolW-1:0] tol_i,
  output logic                     found_o,
  output logic [AW-1:0]            best_o,
  output logic                     done_o
);
  import vwib_pkg::*;

  logic [CW:0]     dx, dy, dz;
  logic [CW:0]     dx_q, dy_q, dz_q;
  logic [2*CW+1:0] px_q, py_q, pz_q;
  logic [DistW-1:0] sq_sum;
  logic [DistW-1:0] best_dist_q;
  logic [AW-1:0]   a1_q, a2_q;
  logic [CW:0]     bdx_q, bdy_q, bdz_q;
  logic            v1_q, v2_q, l1_q, l2_q, have_q, done_q;
  logic            better;

  function automatic logic [CW:0] absd(logic signed [CW-1:0] p, logic signed [CW-1:0] q);
    logic signed [CW:0] d;
    d = {p[CW-1], p} - {q[CW-1], q};
    return d[CW] ? (~d + 1'b1) : d;
  endfunction

  assign dx = absd(cx_i, sx_i);
  assign dy = absd(cy_i, sy_i);
  assign dz = absd(cz_i, sz_i);

  always_ff @(posedge clk_i) begin
    dx_q <= dx;
    dy_q <= dy;
    dz_q <= dz;
    a1_q <= addr_i;
    px_q <= dx_q * dx_q;
    py_q <= dy_q * dy_q;
    pz_q <= dz_q * dz_q;
    a2_q <= a1_q;
  end

  // Second stage holds the absolute differences alongside the squares.
  logic [CW:0] dx2_q, dy2_q, dz2_q;
  always_ff @(posedge clk_i) begin
    dx2_q <= dx_q;
    dy2_q <= dy_q;
    dz2_q <= dz_q;
  end

  assign sq_sum = DistW'(px_q) + DistW'(py_q) + DistW'(pz_q);
  assign better = !have_q || (sq_sum < best_dist_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      l1_q <= 1'b0;
      l2_q <= 1'b0;
      have_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.valid;
      l1_q <= ctrl_i.valid && ctrl_i.last;
      v2_q <= v1_q;
      l2_q <= l1_q;
      done_q <= l2_q;
      if (ctrl_i.start) begin
        have_q <= 1'b0;
      end else if (v2_q && better) begin
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && better) begin
      best_dist_q <= sq_sum;
      best_o      <= a2_q;
      bdx_q       <= dx2_q;
      bdy_q       <= dy2_q;
      bdz_q       <= dz2_q;
    end
  end

  assign done_o  = done_q;
  assign found_o = have_q
                && (DistW'(bdx_q) < DistW'(tol_i))
                && (DistW'(bdy_q) < DistW'(tol_i))
                && (DistW'(bdz_q) < DistW'(tol_i));

endmodule

// ----- rtl/vertex_weld_index_builder.sv -----
// A triangle's result follows a scan of one store entry per cycle, the read and the
// three-stage lane pipeline, then a merge and append of corners a, b and c; an empty
// store skips the scan, and a clear returns its result without one.
// One transaction is handled at a time: a new one is taken only once the previous result
// has been taken, so sink stalls hold off the next transaction.
// Reset zeroes the vertex count and sets the tolerance to 66; store words stay undefined.
module vertex_weld_index_builder #(
  parameter int unsigned STORE_DEPTH = 1024,
  parameter int unsigned COORD_BITS  = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Slave stream. tdata: a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (32 b each).
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // kind: 1 clears the store
  // Master stream. tdata: index_a, index_b, index_c, overflow, stored_count, pad.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,
  // Tolerance register write channel.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [30:0]  cfg_data_i
);
  import vwib_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned NW = $clog2(STORE_DEPTH + 1);

  state_e state_q, state_d;
  logic [TolW-1:0] tol_q;
  logic [NW-1:0]   count_q;
  logic [NW-1:0]   scan_q;
  logic [1:0]      app_q;

  // Corner coordinates, truncated and held for the whole transaction.
  logic signed [COORD_BITS-1:0] crd_q [NCorner][3];

  // Vertex store, one word per vertex.
  logic [3*COORD_BITS-1:0] mem [STORE_DEPTH];
  logic [3*COORD_BITS-1:0] rd_q;
  logic                    we;
  logic [AW-1:0]           wa;
  logic [3*COORD_BITS-1:0] wd;
  logic [AW-1:0]           ra_q;
  logic [AW-1:0]           rd_a_q;

  lane_ctrl_t ctrl;
  logic rd_v_q, rd_l_q, rd_s_q;
  logic issue;
  logic issued_last_q;
  logic [NCorner-1:0] found, done;
  logic [AW-1:0]      best [NCorner];

  logic [IdxW-1:0] idx_q [NCorner];
  logic            ovf_q;
  logic            out_v_q;

  logic s_fire, m_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;
  // A new transaction is taken only when idle and the previous result has left.
  assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;
  // The tolerance only changes while nothing is in flight.
  assign cfg_ready_o = (state_q == ST_IDLE) && !out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolW'(66);
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_data_i;
    end
  end

  // Memory read address sweeps 0..count-1; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra_q];
  end

  assign ctrl.start = rd_s_q;
  assign ctrl.valid = rd_v_q;
  assign ctrl.last  = rd_l_q;

  // Each lane compares one corner against the same stored vertex every cycle.
  for (genvar c = 0; c < NCorner; c++) begin : g_lane
    vwib_lane #(.CW(COORD_BITS), .AW(AW)) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .cx_i    (crd_q[c][0]),
      .cy_i    (crd_q[c][1]),
      .cz_i    (crd_q[c][2]),
      .sx_i    (rd_q[COORD_BITS-1:0]),
      .sy_i    (rd_q[2*COORD_BITS-1:COORD_BITS]),
      .sz_i    (rd_q[3*COORD_BITS-1:2*COORD_BITS]),
      .addr_i  (rd_a_q),
      .tol_i   (tol_q),
      .found_o (found[c]),
      .best_o  (best[c]),
      .done_o  (done[c])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_fire && !s_axis_tuser) state_d = ST_SCAN;
      ST_SCAN: if (done[0] || count_q == '0) state_d = ST_DONE;
      ST_DONE: if (app_q == 2'd2) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // The sweep issues every address below the snapshot count exactly once.
  assign issue = (state_q == ST_SCAN) && !issued_last_q && !rd_l_q
              && (NW'(ra_q) < scan_q);

  // Merge/append: one corner per cycle in order a, b, c.
  always_comb begin
    we = 1'b0;
    wa = count_q[AW-1:0];
    wd = {crd_q[app_q][2], crd_q[app_q][1], crd_q[app_q][0]};
    if (state_q == ST_DONE && !(found[app_q] && count_q != '0 && scan_q != '0)
        && count_q < NW'(STORE_DEPTH)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      scan_q <= '0;
      app_q <= '0;
      out_v_q <= 1'b0;
      rd_v_q <= 1'b0;
      rd_l_q <= 1'b0;
      rd_s_q <= 1'b0;
      ra_q <= '0;
      rd_a_q <= '0;
    end else begin
      state_q <= state_d;
      rd_s_q <= s_fire && !s_axis_tuser;
      rd_v_q <= issue;
      rd_l_q <= issue && (NW'(ra_q) == scan_q - 1'b1);
      if (issue) rd_a_q <= ra_q;
      if (state_q == ST_IDLE) begin
        ra_q <= '0;
        scan_q <= (s_fire && !s_axis_tuser) ? count_q : '0;
      end else if (issue) begin
        ra_q <= ra_q + 1'b1;
      end
      if (state_q == ST_DONE) app_q <= (app_q == 2'd2) ? 2'd0 : app_q + 1'b1;
      if (s_fire && s_axis_tuser) count_q <= '0;
      else if (we) count_q <= count_q + 1'b1;
      if (m_fire) begin
        out_v_q <= 1'b0;
      end else if ((s_fire && s_axis_tuser) || (state_q == ST_DONE && app_q == 2'd2)) begin
        out_v_q <= 1'b1;
      end
    end
  end

  // Marks that the last address of the sweep has gone out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) issued_last_q <= 1'b0;
    else if (state_q != ST_SCAN) issued_last_q <= 1'b0;
    else if (rd_l_q) issued_last_q <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      for (int c = 0; c < NCorner; c++) begin
        for (int k = 0; k < 3; k++) begin
          crd_q[c][k] <= s_axis_tdata[(c*3+k)*FieldW +: COORD_BITS];
        end
        idx_q[c] <= '0;
      end
      ovf_q <= 1'b0;
    end else if (state_q == ST_DONE) begin
      if (found[app_q] && scan_q != '0) begin
        idx_q[app_q] <= IdxW'(best[app_q]);
      end else if (count_q < NW'(STORE_DEPTH)) begin
        idx_q[app_q] <= IdxW'(count_q);
      end else begin
        idx_q[app_q] <= '0;
        ovf_q <= 1'b1;
      end
    end
  end

  // The count is stable while a result waits, since no transaction is taken then.
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {6'd0, CountW'(count_q), ovf_q, idx_q[2], idx_q[1], idx_q[0]};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NW'(STORE_DEPTH)) else $error("vertex count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tuser |=> count_q == '0) else $error("clear failed");

endmodule
